// File: hdl/flvp_pkg.sv
package flvp_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_AUDIO_CODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_CODE = 1'd1;

  localparam logic [7:0] AUDIO_CODE_RST = 8'd8;
  localparam logic [7:0] VIDEO_CODE_RST = 8'd9;

  // File signature bytes 'F', 'L', 'V'.
  localparam logic [7:0] SIG_F = 8'h46;
  localparam logic [7:0] SIG_L = 8'h4C;
  localparam logic [7:0] SIG_V = 8'h56;

  localparam logic [2:0] EV_FILE_HDR  = 3'd0;
  localparam logic [2:0] EV_TAG_HDR   = 3'd1;
  localparam logic [2:0] EV_VIDEO_HDR = 3'd2;
  localparam logic [2:0] EV_PAYLOAD   = 3'd3;
  localparam logic [2:0] EV_TAG_END   = 3'd4;
  localparam logic [2:0] EV_BAD_SIG   = 3'd5;
  localparam logic [2:0] EV_BAD_TYPE  = 3'd6;
  localparam logic [2:0] EV_BAD_RSVD  = 3'd7;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  file_version;
    logic [7:0]  file_flags;
    logic [31:0] header_offset;
    logic [31:0] first_prev_size;
    logic [7:0]  tag_kind;
    logic [23:0] body_size;
    logic [23:0] time_stamp;
    logic [7:0]  video_header;
    logic [7:0]  payload_value;
    logic [31:0] trailer_length;
  } result_t;

endpackage

// File: hdl/flvp_in_stage.sv
module flvp_in_stage
  import flvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  output logic       in_stall,
  input  logic       slot_free,
  output logic       take,
  output logic [7:0] byte_q
);

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_stall = valid_r && !slot_free;
  assign take     = valid_r && slot_free;
  assign byte_q   = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_data_byte;
    end
  end

endmodule

// File: hdl/flvp_parser.sv
module flvp_parser
  import flvp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] byte_q,
  input  logic [7:0] audio_code,
  input  logic [7:0] video_code,
  output logic       res_load,
  output result_t    res
);

  typedef enum logic [3:0] {
    PH_SIG, PH_VER, PH_FLAGS, PH_OFFSET, PH_PREV0, PH_TYPE, PH_SIZE,
    PH_TIME, PH_RSVD, PH_SKIP, PH_VHDR, PH_PAYLOAD, PH_TRAILER, PH_STOP
  } phase_t;

  localparam logic [1:0] LAST_OF_3 = 2'd2;
  localparam logic [1:0] LAST_OF_4 = 2'd3;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [23:0] remain_r, remain_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [23:0] size_r, size_nxt;
  logic [23:0] time_r, time_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  ver_r, ver_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [31:0] offset_r, offset_nxt;

  logic [31:0] acc_shift;
  logic [23:0] remain_dec;
  logic [1:0]  cnt_inc;

  assign acc_shift  = {acc_r[23:0], byte_q};
  assign remain_dec = remain_r - 24'd1;
  assign cnt_inc    = cnt_r + 2'd1;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    remain_nxt = remain_r;
    type_nxt   = type_r;
    size_nxt   = size_r;
    time_nxt   = time_r;
    acc_nxt    = acc_r;
    ver_nxt    = ver_r;
    flags_nxt  = flags_r;
    offset_nxt = offset_r;
    res_load   = 1'b0;
    res        = '0;
    if (take) begin
      unique case (phase_r)
        PH_SIG: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          if (cnt_r == LAST_OF_3) begin
            cnt_nxt = 2'd0;
            if (acc_shift[23:0] != {SIG_F, SIG_L, SIG_V}) begin
              phase_nxt      = PH_STOP;
              res_load       = 1'b1;
              res.event_kind = EV_BAD_SIG;
            end else begin
              acc_nxt   = '0;
              phase_nxt = PH_VER;
            end
          end
        end
        PH_VER: begin
          ver_nxt   = byte_q;
          phase_nxt = PH_FLAGS;
        end
        PH_FLAGS: begin
          flags_nxt = byte_q;
          phase_nxt = PH_OFFSET;
          cnt_nxt   = 2'd0;
          acc_nxt   = '0;
        end
        PH_OFFSET: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          if (cnt_r == LAST_OF_4) begin
            offset_nxt = acc_shift;
            cnt_nxt    = 2'd0;
            acc_nxt    = '0;
            phase_nxt  = PH_PREV0;
          end
        end
        PH_PREV0: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          if (cnt_r == LAST_OF_4) begin
            res_load            = 1'b1;
            res.event_kind      = EV_FILE_HDR;
            res.file_version    = ver_r;
            res.file_flags      = flags_r;
            res.header_offset   = offset_r;
            res.first_prev_size = acc_shift;
            cnt_nxt             = 2'd0;
            acc_nxt             = '0;
            phase_nxt           = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_nxt = byte_q;
          if (byte_q != audio_code && byte_q != video_code) begin
            phase_nxt      = PH_STOP;
            res_load       = 1'b1;
            res.event_kind = EV_BAD_TYPE;
            res.tag_kind   = byte_q;
          end else begin
            cnt_nxt   = 2'd0;
            acc_nxt   = '0;
            phase_nxt = PH_SIZE;
          end
        end
        PH_SIZE: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          if (cnt_r == LAST_OF_3) begin
            size_nxt  = acc_shift[23:0];
            cnt_nxt   = 2'd0;
            acc_nxt   = '0;
            phase_nxt = PH_TIME;
          end
        end
        PH_TIME: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          if (cnt_r == LAST_OF_3) begin
            time_nxt  = acc_shift[23:0];
            cnt_nxt   = 2'd0;
            acc_nxt   = '0;
            phase_nxt = PH_RSVD;
          end
        end
        PH_RSVD: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          if (cnt_r == LAST_OF_4) begin
            res_load = 1'b1;
            if (acc_shift != 32'd0) begin
              phase_nxt      = PH_STOP;
              res.event_kind = EV_BAD_RSVD;
            end else begin
              res.event_kind = EV_TAG_HDR;
              res.tag_kind   = type_r;
              res.body_size  = size_r;
              res.time_stamp = time_r;
              remain_nxt     = size_r;
              cnt_nxt        = 2'd0;
              acc_nxt        = '0;
              // An empty body goes straight to the trailer; audio wins a tie.
              if (size_r == 24'd0) begin
                phase_nxt = PH_TRAILER;
              end else if (type_r == audio_code) begin
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = PH_VHDR;
              end
            end
          end
        end
        PH_SKIP: begin
          remain_nxt = remain_dec;
          if (remain_dec == 24'd0) begin
            phase_nxt = PH_TRAILER;
            cnt_nxt   = 2'd0;
            acc_nxt   = '0;
          end
        end
        PH_VHDR: begin
          res_load         = 1'b1;
          res.event_kind   = EV_VIDEO_HDR;
          res.video_header = byte_q;
          remain_nxt       = remain_dec;
          phase_nxt        = (remain_dec == 24'd0) ? PH_TRAILER : PH_PAYLOAD;
          cnt_nxt          = 2'd0;
          acc_nxt          = '0;
        end
        PH_PAYLOAD: begin
          res_load          = 1'b1;
          res.event_kind    = EV_PAYLOAD;
          res.payload_value = byte_q;
          remain_nxt        = remain_dec;
          if (remain_dec == 24'd0) begin
            phase_nxt = PH_TRAILER;
            cnt_nxt   = 2'd0;
            acc_nxt   = '0;
          end
        end
        PH_TRAILER: begin
          acc_nxt = acc_shift;
          cnt_nxt = cnt_inc;
          if (cnt_r == LAST_OF_4) begin
            res_load           = 1'b1;
            res.event_kind     = EV_TAG_END;
            res.trailer_length = acc_shift;
            cnt_nxt            = 2'd0;
            acc_nxt            = '0;
            phase_nxt          = PH_TYPE;
          end
        end
        PH_STOP: begin
          phase_nxt = PH_STOP;
        end
        default: begin
          phase_nxt = PH_STOP;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SIG;
      cnt_r    <= 2'd0;
      remain_r <= '0;
      type_r   <= '0;
      size_r   <= '0;
      time_r   <= '0;
      acc_r    <= '0;
      ver_r    <= '0;
      flags_r  <= '0;
      offset_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      remain_r <= remain_nxt;
      type_r   <= type_nxt;
      size_r   <= size_nxt;
      time_r   <= time_nxt;
      acc_r    <= acc_nxt;
      ver_r    <= ver_nxt;
      flags_r  <= flags_nxt;
      offset_r <= offset_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOP |=> phase_r == PH_STOP)
    else $error("parser left the stopped state");
  a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SKIP || phase_r == PH_VHDR || phase_r == PH_PAYLOAD)
      |-> remain_r != 24'd0)
    else $error("body phase with no bytes left");
  a_no_event_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !take |-> !res_load)
    else $error("event produced without a byte");
`endif

endmodule

// File: hdl/flvp_out_stage.sv
module flvp_out_stage
  import flvp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_load,
  input  result_t res,
  input  logic    out_stall,
  output logic    out_valid,
  output result_t res_q,
  output logic    slot_free
);

  logic    valid_r;
  result_t res_r;

  assign slot_free = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign res_q     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (slot_free) begin
      valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_load_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> slot_free)
    else $error("result loaded over a waiting result");
`endif

endmodule

// File: hdl/flv_tag_parser_top.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_data_byte
// out      output     out_valid / out_stall out_event_kind .. out_trailer_length
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// One byte per cycle is taken while in_stall is low; a result passes from the input register through the
// parser into the result register before it can transfer. The parser's phase and field update per byte sets that rate.
// Synchronous active-low reset returns the parser to the signature check.
// A stall on a waiting result holds the result register and, in the same cycle, the
// input register when that register holds a byte.
module flv_tag_parser_top
  import flvp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [7:0]            in_data_byte,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            out_event_kind,
  output logic [7:0]            out_file_version,
  output logic [7:0]            out_file_flags,
  output logic [31:0]           out_header_offset,
  output logic [31:0]           out_first_prev_size,
  output logic [7:0]            out_tag_kind,
  output logic [23:0]           out_body_size,
  output logic [23:0]           out_time_stamp,
  output logic [7:0]            out_video_header,
  output logic [7:0]            out_payload_value,
  output logic [31:0]           out_trailer_length,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0] audio_code_r;
  logic [7:0] video_code_r;
  logic       slot_free;
  logic       take;
  logic [7:0] byte_q;
  logic       res_load;
  result_t    res;
  result_t    res_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      audio_code_r <= AUDIO_CODE_RST;
      video_code_r <= VIDEO_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUDIO_CODE: audio_code_r <= cfg_wdata;
        CFG_VIDEO_CODE: video_code_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  flvp_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_stall     (in_stall),
    .slot_free    (slot_free),
    .take         (take),
    .byte_q       (byte_q)
  );

  flvp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .byte_q     (byte_q),
    .audio_code (audio_code_r),
    .video_code (video_code_r),
    .res_load   (res_load),
    .res        (res)
  );

  flvp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_load  (res_load),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .res_q     (res_q),
    .slot_free (slot_free)
  );

  assign out_event_kind      = res_q.event_kind;
  assign out_file_version    = res_q.file_version;
  assign out_file_flags      = res_q.file_flags;
  assign out_header_offset   = res_q.header_offset;
  assign out_first_prev_size = res_q.first_prev_size;
  assign out_tag_kind        = res_q.tag_kind;
  assign out_body_size       = res_q.body_size;
  assign out_time_stamp      = res_q.time_stamp;
  assign out_video_header    = res_q.video_header;
  assign out_payload_value   = res_q.payload_value;
  assign out_trailer_length  = res_q.trailer_length;

endmodule
